// ===== design/mfsgd_pkg.sv =====
// Package: shared constants and types for the matrix factorization SGD engine
`default_nettype none
package mfsgd_pkg;
  localparam int NumUsers   = 1024;
  localparam int NumItems   = 1024;
  localparam int MaxFactors = 16;
  localparam int RowW  = $clog2(NumUsers);
  localparam int FacW  = $clog2(MaxFactors);
  localparam int AddrW = RowW + FacW;

  localparam logic [2:0] OP_LOAD_USER = 3'd0;
  localparam logic [2:0] OP_LOAD_ITEM = 3'd1;
  localparam logic [2:0] OP_TRAIN     = 3'd2;
  localparam logic [2:0] OP_EVAL      = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;

  localparam logic [1:0] REG_LR  = 2'd0;
  localparam logic [1:0] REG_REG = 2'd1;
  localparam logic [1:0] REG_NF  = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [9:0]  user_index;
    logic [9:0]  item_index;
    logic [3:0]  factor_index;
    logic signed [31:0] factor_value;
    logic signed [31:0] rating;
    logic        rating_missing;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] error;
    logic [63:0] loss_sum;
    logic [31:0] rating_count;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DRD, S_DWAIT, S_DMAC, S_ERR,
    S_URD, S_UWAIT, S_UMUL, S_UFIN, S_VMUL, S_VFIN,
    S_LOSS, S_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== design/mfsgd_if.sv =====
// Interface: valid/ready channel carrying one beat of payload
`default_nettype none
interface mfsgd_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/matrix_factorization_sgd_step.sv =====
// Top level: matrix factorization SGD engine with a shared multiplier
// One item at a time. The input is not ready while an item is in work or its result waits.
// A load, a clear or an unused op code goes from decode straight to the output state.
// Train and evaluate share one registered 33x33 multiplier and one RAM port per table.
// The dot product takes a read wait and a multiply-accumulate step per factor. Decode,
// the error step, the loss square (a multiply, then an accumulate) and the output register
// are added to it.
// Train adds, for each factor:
//   - a row read and its wait;
//   - six multiplier steps each for the user update and the item update (error product,
//     regularization product, a gap, two partial products of the scaled step, rounding);
//   - a write-back for each.
// With no factors in use, train and evaluate skip the dot product and the updates.
// The result sits in an output register. The next item is taken the cycle after the
// result beat leaves, so a new load is not taken before the last one's result has left.
`default_nettype none
module matrix_factorization_sgd_step (
  input wire logic clk,
  input wire logic rst,
  input wire logic        cfg_we,
  input wire logic [1:0]  cfg_index,
  input wire logic [23:0] cfg_data,
  mfsgd_if.sink   in_ch,
  mfsgd_if.source out_ch
);
  localparam int AW = mfsgd_pkg::AddrW;
  localparam int FW = mfsgd_pkg::FacW;

  mfsgd_pkg::state_t state, state_next;
  mfsgd_pkg::in_beat_t cur;
  logic [23:0] lr, rg;
  logic [4:0]  nf;
  logic [FW:0] n, j;
  logic [63:0] loss;
  logic [31:0] cnt;
  logic signed [65:0] acc;
  logic [20:0] lo;
  logic signed [31:0] err, uval, vval, own;
  logic [65:0] dmag;
  logic        dneg;
  logic [2:0]  ph;
  logic        side;
  logic        ovalid;
  mfsgd_pkg::out_beat_t obeat;

  logic u_we, v_we;
  logic [AW-1:0] u_addr, v_addr;
  logic [31:0] u_wdata, v_wdata, u_rdata, v_rdata;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;

  mfsgd_ram #(.Depth(1 << AW), .Width(32)) u_tab (
    .clk(clk), .we(u_we), .addr(u_addr), .wdata(u_wdata), .rdata(u_rdata));
  mfsgd_ram #(.Depth(1 << AW), .Width(32)) v_tab (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata));
  mfsgd_mul mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  logic accum_op;
  assign accum_op = (cur.op == mfsgd_pkg::OP_TRAIN || cur.op == mfsgd_pkg::OP_EVAL)
                    && !cur.rating_missing;

  assign in_ch.ready  = (state == mfsgd_pkg::S_IDLE) && !ovalid;
  assign out_ch.valid = ovalid;
  assign out_ch.data  = obeat;

  // scaled step: mag*lr/2^39 rounded, built from two partial products
  logic signed [65:0] sum_new;
  logic [65:0] lo_part, step_r;
  assign lo_part = {27'd0, mp[6:0], 32'd0} + $unsigned(acc) + 66'h40_0000_0000;
  assign step_r = {7'd0, mp[65:7]} + {39'd0, lo_part[65:39]};
  assign sum_new = dneg ? ($signed({{34{own[31]}}, own}) - acc)
                        : ($signed({{34{own[31]}}, own}) + acc);

  // drop the stale product when no factor is in use
  logic signed [65:0] mp_last;
  logic [20:0] lo_sum;
  assign mp_last = (n == '0) ? '0 : mp;
  assign lo_sum = lo + {5'd0, mp_last[15:0]} + 21'h8000;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state) inside
      mfsgd_pkg::S_DMAC: begin
        ma = {u_rdata[31], u_rdata};
        mb = {v_rdata[31], v_rdata};
      end
      mfsgd_pkg::S_LOSS: begin
        ma = {err[31], err};
        mb = {err[31], err};
      end
      mfsgd_pkg::S_UMUL, mfsgd_pkg::S_VMUL: begin
        case (ph)
          3'd0: begin
            ma = {err[31], err};
            mb = (state == mfsgd_pkg::S_UMUL) ? {vval[31], vval} : {uval[31], uval};
          end
          3'd1: begin
            ma = $signed({9'd0, rg});
            mb = {own[31], own};
          end
          3'd3: begin
            ma = $signed({1'b0, dmag[31:0]});
            mb = $signed({9'd0, lr});
          end
          3'd4: begin
            ma = $signed({1'b0, dmag[63:32]});
            mb = $signed({9'd0, lr});
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mfsgd_pkg::S_IDLE:   if (in_ch.valid && in_ch.ready) state_next = mfsgd_pkg::S_DRD;
      mfsgd_pkg::S_DRD:    state_next = (accum_op && n != '0) ? mfsgd_pkg::S_DWAIT
                                        : accum_op ? mfsgd_pkg::S_ERR : mfsgd_pkg::S_OUT;
      mfsgd_pkg::S_DWAIT:  state_next = mfsgd_pkg::S_DMAC;
      mfsgd_pkg::S_DMAC:   state_next = (j == n - 1'b1) ? mfsgd_pkg::S_ERR
                                        : mfsgd_pkg::S_DWAIT;
      mfsgd_pkg::S_ERR:    state_next = (cur.op == mfsgd_pkg::OP_TRAIN && n != '0)
                                        ? mfsgd_pkg::S_URD : mfsgd_pkg::S_LOSS;
      mfsgd_pkg::S_URD:    state_next = mfsgd_pkg::S_UWAIT;
      mfsgd_pkg::S_UWAIT:  state_next = mfsgd_pkg::S_UMUL;
      mfsgd_pkg::S_UMUL:   if (ph == 3'd5) state_next = mfsgd_pkg::S_UFIN;
      mfsgd_pkg::S_UFIN:   state_next = mfsgd_pkg::S_VMUL;
      mfsgd_pkg::S_VMUL:   if (ph == 3'd5) state_next = mfsgd_pkg::S_VFIN;
      mfsgd_pkg::S_VFIN:   state_next = (j == n - 1'b1) ? mfsgd_pkg::S_LOSS
                                        : mfsgd_pkg::S_URD;
      mfsgd_pkg::S_LOSS:   if (side) state_next = mfsgd_pkg::S_OUT;
      mfsgd_pkg::S_OUT:    state_next = mfsgd_pkg::S_IDLE;
      default:             state_next = mfsgd_pkg::S_IDLE;
    endcase
  end

  // RAM addressing and writes
  always_comb begin
    u_we = 1'b0;
    v_we = 1'b0;
    u_wdata = cur.factor_value;
    v_wdata = cur.factor_value;
    u_addr = {cur.user_index, cur.factor_index};
    v_addr = {cur.item_index, cur.factor_index};
    if (state == mfsgd_pkg::S_DRD) begin
      u_we = (cur.op == mfsgd_pkg::OP_LOAD_USER);
      v_we = (cur.op == mfsgd_pkg::OP_LOAD_ITEM);
    end else if (state != mfsgd_pkg::S_IDLE) begin
      u_addr = {cur.user_index, j[FW-1:0]};
      v_addr = {cur.item_index, j[FW-1:0]};
      if (state == mfsgd_pkg::S_UFIN) begin
        u_we = 1'b1;
        u_wdata = mfsgd_pkg::sat32(sum_new);
      end
      if (state == mfsgd_pkg::S_VFIN) begin
        v_we = 1'b1;
        v_wdata = mfsgd_pkg::sat32(sum_new);
      end
    end
  end

  logic signed [65:0] dval;
  assign dval = acc - ($signed(mp) >>> 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfsgd_pkg::S_IDLE;
      lr <= 24'd5033;
      rg <= 24'd32768;
      nf <= 5'd5;
      loss <= '0;
      cnt <= '0;
      ovalid <= 1'b0;
      ph <= '0;
      side <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          mfsgd_pkg::REG_LR:  lr <= cfg_data;
          mfsgd_pkg::REG_REG: rg <= cfg_data;
          mfsgd_pkg::REG_NF:  nf <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) ovalid <= 1'b0;
      if (state == mfsgd_pkg::S_OUT) ovalid <= 1'b1;
      if (state == mfsgd_pkg::S_DRD && cur.op == mfsgd_pkg::OP_CLEAR) begin
        loss <= '0;
        cnt <= '0;
      end
      if (state == mfsgd_pkg::S_LOSS && side) begin
        loss <= (loss > ~mp[63:0]) ? '1 : loss + mp[63:0];
        if (cnt != '1) cnt <= cnt + 32'd1;
      end
      if (state == mfsgd_pkg::S_LOSS) side <= ~side;
      if (state == mfsgd_pkg::S_UMUL || state == mfsgd_pkg::S_VMUL) ph <= ph + 3'd1;
      else ph <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cur <= in_ch.data;
      n <= (nf > 5'(mfsgd_pkg::MaxFactors)) ? (FW+1)'(mfsgd_pkg::MaxFactors) : nf[FW:0];
      err <= '0;
    end
    unique case (state) inside
      mfsgd_pkg::S_DRD: begin
        j <= '0;
        acc <= '0;
        lo <= '0;
      end
      mfsgd_pkg::S_DMAC: j <= j + 1'b1;
      mfsgd_pkg::S_DWAIT: if (j != '0) begin
        acc <= acc + (mp >>> 16);
        lo <= lo + {5'd0, mp[15:0]};
      end
      mfsgd_pkg::S_ERR: begin
        err <= mfsgd_pkg::sat32($signed({{34{cur.rating[31]}}, cur.rating})
               - (acc + (mp_last >>> 16) + $signed({61'd0, lo_sum[20:16]})));
        j <= '0;
      end
      mfsgd_pkg::S_URD: ;
      mfsgd_pkg::S_UWAIT: begin
        uval <= u_rdata;
        vval <= v_rdata;
        own <= u_rdata;
      end
      mfsgd_pkg::S_UMUL, mfsgd_pkg::S_VMUL: begin
        case (ph)
          3'd1: acc <= mp;
          3'd2: begin
            dneg <= dval[65];
            dmag <= dval[65] ? 66'(-dval) : dval;
          end
          3'd4: acc <= mp;
          3'd5: acc <= $signed(step_r);
          default: ;
        endcase
      end
      mfsgd_pkg::S_UFIN: begin
        uval <= mfsgd_pkg::sat32(sum_new);
        own <= vval;
      end
      mfsgd_pkg::S_VFIN: j <= j + 1'b1;
      default: ;
    endcase
    if (state == mfsgd_pkg::S_DMAC && j == '0) begin
      acc <= '0;
      lo <= '0;
    end
    if (state == mfsgd_pkg::S_OUT) begin
      obeat.error <= err;
      obeat.loss_sum <= loss;
      obeat.rating_count <= cnt;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == mfsgd_pkg::S_IDLE)
    else $error("ready outside idle");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("accept while result pending");
`endif
endmodule
`default_nettype wire

// ===== design/mfsgd_ram.sv =====
// Generic single-port RAM with registered read
`default_nettype none
module mfsgd_ram #(
  parameter int Depth = 16,
  parameter int Width = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== design/mfsgd_mul.sv =====
// Shared registered 33x33 signed multiplier
`default_nettype none
module mfsgd_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic signed [65:0]      p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule
`default_nettype wire

// ===== tb/mfsgd_checker.sv =====
// Checker: watches the item and result channels, predicts each result and compares it
`default_nettype none
module mfsgd_checker
  import mfsgd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire in_beat_t    in_data,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire out_beat_t   out_data,
  output int               fail_count,
  output int               pending,
  output int               checked
);
  logic signed [31:0] user_tab [NumUsers*MaxFactors];
  logic signed [31:0] item_tab [NumItems*MaxFactors];
  bit [63:0]  loss_acc;
  bit [31:0]  count_acc;
  bit [23:0]  step_rate;
  bit [23:0]  reg_weight;
  bit [4:0]   nfac;
  out_beat_t  expected_q[$];
  out_beat_t  want;

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic logic signed [31:0] sat(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // d*lr/2^39, magnitude rounded half away from zero
  function automatic longint scale_step(input longint d, input bit [23:0] lr);
    bit [63:0] mag, hi, lo, low_part, r;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    hi = (mag >> 32) * 64'(lr);
    lo = (mag & 64'hFFFF_FFFF) * 64'(lr);
    low_part = ((hi & 64'd127) << 32) + lo + (64'd1 << 38);
    r = (hi >> 7) + (low_part >> 39);
    return (d < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [31:0] stepped(input logic signed [31:0] own,
                                                 input logic signed [31:0] other,
                                                 input longint e);
    longint d;
    d = e * longint'(other) - ((longint'(reg_weight) * longint'(own)) >>> 2);
    return sat(longint'(own) + scale_step(d, step_rate));
  endfunction

  function automatic out_beat_t sgd_apply(input in_beat_t b);
    longint hi, err, prod;
    bit [63:0] lo, sq;
    int n, bu, bv;
    logic signed [31:0] nu;
    err = 0;
    bu = int'(b.user_index) * MaxFactors;
    bv = int'(b.item_index) * MaxFactors;
    case (b.op) inside
      OP_LOAD_USER: user_tab[bu + int'(b.factor_index)] = b.factor_value;
      OP_LOAD_ITEM: item_tab[bv + int'(b.factor_index)] = b.factor_value;
      OP_TRAIN, OP_EVAL: begin
        if (!b.rating_missing) begin
          n = (nfac > MaxFactors) ? MaxFactors : int'(nfac);
          hi = 0;
          lo = 0;
          for (int j = 0; j < n; j++) begin
            prod = longint'(user_tab[bu + j]) * longint'(item_tab[bv + j]);
            hi += prod >>> 16;
            lo += 64'(prod) & 64'hFFFF;
          end
          hi += longint'((lo + 64'h8000) >> 16);
          err = longint'(sat(longint'(b.rating) - hi));
          if (b.op == OP_TRAIN) begin
            for (int j = 0; j < n; j++) begin
              nu = stepped(user_tab[bu + j], item_tab[bv + j], err);
              user_tab[bu + j] = nu;
              item_tab[bv + j] = stepped(item_tab[bv + j], nu, err);
            end
          end
          sq = 64'(err * err);
          loss_acc = (loss_acc > ~64'd0 - sq) ? ~64'd0 : loss_acc + sq;
          if (count_acc != 32'hFFFF_FFFF) count_acc++;
        end
      end
      OP_CLEAR: begin
        loss_acc = 0;
        count_acc = 0;
      end
      default: ;
    endcase
    return '{error: err[31:0], loss_sum: loss_acc, rating_count: count_acc};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      loss_acc = 0;
      count_acc = 0;
      step_rate = 24'd5033;
      reg_weight = 24'd32768;
      nfac = 5'd5;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LR:  step_rate = cfg_data;
          REG_REG: reg_weight = cfg_data;
          REG_NF:  nfac = cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (out_data.error !== want.error)
            report($sformatf("error %h, want %h", out_data.error, want.error));
          if (out_data.loss_sum !== want.loss_sum)
            report($sformatf("loss_sum %h, want %h", out_data.loss_sum, want.loss_sum));
          if (out_data.rating_count !== want.rating_count)
            report($sformatf("rating_count %0d, want %0d",
                             out_data.rating_count, want.rating_count));
        end
      end
      if (in_valid && in_ready) expected_q.push_back(sgd_apply(in_data));
    end
    pending = expected_q.size();
  end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench top: drives items, registers and result stalls, and gives the verdict
`default_nettype none
module tb_top;
  import mfsgd_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;
  localparam int CycleLimit = 3000000;
  localparam int PoolSize = 4;
  localparam int Phases = 6;
  localparam int RandPerPhase = 135;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_LR;
  logic [23:0] cfg_data = '0;
  int          fail_count, pending, checked;
  int          cycles = 0;
  int          sent = 0;
  int          rx_gap = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_rx = 1'b0;
  int          user_pool[PoolSize];
  int          item_pool[PoolSize];

  always #6 clk = ~clk;

  mfsgd_if #(.T(in_beat_t))  in_ch(clk);
  mfsgd_if #(.T(out_beat_t)) out_ch(clk);

  matrix_factorization_sgd_step DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  mfsgd_checker chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_rx) begin
      out_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      rx_gap = $urandom_range(0, 5);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    wait (hold_req);
    hold_rx = 1'b1;
    repeat (400) @(posedge clk);
    hold_rx = 1'b0;
  end

  task automatic send(input in_beat_t b);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_factor();
    if ($urandom_range(0, 15) == 0) return $urandom;
    return $signed($urandom_range(0, 262143)) - 32'sd131072;
  endfunction

  function automatic logic signed [31:0] rand_rating();
    if ($urandom_range(0, 15) == 0) return $urandom;
    return $urandom_range(0, 5 << 16);
  endfunction

  function automatic in_beat_t make_beat(input logic [2:0] op, input int u, input int v,
                                         input int f, input logic signed [31:0] val,
                                         input logic signed [31:0] rating,
                                         input bit missing);
    in_beat_t b;
    b.op = op;
    b.user_index = u[9:0];
    b.item_index = v[9:0];
    b.factor_index = f[3:0];
    b.factor_value = val;
    b.rating = rating;
    b.rating_missing = missing;
    return b;
  endfunction

  function automatic in_beat_t rand_beat();
    in_beat_t b;
    int sel, u, v;
    b = make_beat(OP_TRAIN, 0, 0, $urandom_range(0, 15), $urandom, rand_rating(), 1'b0);
    u = user_pool[$urandom_range(0, PoolSize - 1)];
    v = item_pool[$urandom_range(0, PoolSize - 1)];
    b.user_index = u[9:0];
    b.item_index = v[9:0];
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      b.op = OP_LOAD_USER;
      b.factor_value = rand_factor();
      if (sel < 3) b.user_index = 10'($urandom);
    end else if (sel < 16) begin
      b.op = OP_LOAD_ITEM;
      b.factor_value = rand_factor();
      if (sel < 11) b.item_index = 10'($urandom);
    end else if (sel < 60) begin
      b.op = OP_TRAIN;
    end else if (sel < 82) begin
      b.op = OP_EVAL;
    end else if (sel < 85) begin
      b.op = OP_CLEAR;
    end else if (sel < 90) begin
      b.op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
      b.user_index = 10'($urandom);
      b.item_index = 10'($urandom);
    end else begin
      b.op = ($urandom_range(0, 1) == 0) ? OP_TRAIN : OP_EVAL;
      b.rating_missing = 1'b1;
    end
    return b;
  endfunction

  task automatic load_pool();
    for (int r = 0; r < PoolSize; r++) begin
      for (int f = 0; f < MaxFactors; f++) begin
        send(make_beat(OP_LOAD_USER, user_pool[r], $urandom, f, rand_factor(), $urandom,
                       1'($urandom_range(0, 1))));
        send(make_beat(OP_LOAD_ITEM, $urandom, item_pool[r], f, rand_factor(), $urandom,
                       1'($urandom_range(0, 1))));
      end
    end
  endtask

  task automatic directed_items();
    int u0, v0;
    u0 = user_pool[2];
    v0 = item_pool[2];
    send(make_beat(OP_TRAIN, u0, v0, 0, 0, 32'sh0005_0000, 1'b0));
    send(make_beat(OP_EVAL, u0, v0, 0, 0, 32'sh0005_0000, 1'b0));
    send(make_beat(OP_TRAIN, u0, v0, 0, 0, 32'sh0003_0000, 1'b1));
    send(make_beat(OP_EVAL, u0, v0, 0, 0, 32'sh0003_0000, 1'b1));
    send(make_beat(OP_TRAIN, u0, v0, 0, 0, 32'sh7fffffff, 1'b0));
    send(make_beat(OP_TRAIN, u0, v0, 0, 0, 32'sh80000000, 1'b0));
    send(make_beat(OP_SPARE_A, 1023, 1023, 15, $urandom, $urandom, 1'b0));
    send(make_beat(OP_SPARE_B, 0, 0, 0, $urandom, $urandom, 1'b1));
    send(make_beat(OP_SPARE_C, 512, 511, 7, $urandom, $urandom, 1'b0));
    send(make_beat(OP_CLEAR, 0, 0, 0, 0, 0, 1'b0));
    send(make_beat(OP_LOAD_USER, 1023, 0, 15, 32'sh7fffffff, 0, 1'b0));
    send(make_beat(OP_LOAD_ITEM, 0, 1023, 15, 32'sh7fffffff, 0, 1'b0));
    send(make_beat(OP_LOAD_USER, 1023, 0, 0, 32'sh80000000, 0, 1'b0));
    send(make_beat(OP_LOAD_ITEM, 0, 1023, 0, 32'sh80000000, 0, 1'b0));
    send(make_beat(OP_EVAL, 1023, 1023, 0, 0, 32'sh80000000, 1'b0));
    send(make_beat(OP_TRAIN, 1023, 1023, 0, 0, 32'sh7fffffff, 1'b0));
    send(make_beat(OP_TRAIN, 1023, 1023, 0, 0, 32'sh80000000, 1'b0));
    send(make_beat(OP_EVAL, 0, 0, 0, 0, 0, 1'b0));
    send(make_beat(OP_LOAD_USER, 517, 0, 7, 0, 0, 1'b0));
    send(make_beat(OP_CLEAR, 1023, 1023, 15, $urandom, $urandom, 1'b1));
  endtask

  initial begin
    user_pool[0] = 0;
    item_pool[0] = 0;
    user_pool[1] = 1023;
    item_pool[1] = 1023;
    for (int r = 2; r < PoolSize; r++) begin
      user_pool[r] = $urandom_range(1, 1022);
      item_pool[r] = $urandom_range(1, 1022);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < Phases; p++) begin
      idle_on = (p < Phases - 1);
      case (p)
        1: begin
          write_reg(REG_LR, 24'd0);
          write_reg(REG_REG, 24'd0);
          write_reg(REG_NF, 24'd1);
        end
        2: begin
          write_reg(REG_LR, 24'hFFFFFF);
          write_reg(REG_REG, 24'hFFFFFF);
          write_reg(REG_NF, 24'd16);
        end
        3: begin
          write_reg(REG_LR, 24'($urandom));
          write_reg(REG_REG, 24'($urandom));
          write_reg(REG_NF, 24'd0);
        end
        4: begin
          write_reg(REG_LR, 24'($urandom_range(0, 65535)));
          write_reg(REG_REG, 24'($urandom));
          write_reg(REG_NF, 24'd31);
        end
        5: begin
          write_reg(REG_LR, 24'd5033);
          write_reg(REG_REG, 24'd32768);
          write_reg(REG_NF, 24'($urandom_range(1, 16)));
        end
        default: ;
      endcase
      cfg_we <= 1'b0;
      load_pool();
      if (p == 0) directed_items();
      for (int k = 0; k < RandPerPhase; k++) begin
        if (p == 1 && k == 20) hold_req = 1'b1;
        send(rand_beat());
      end
      settle();
    end
    repeat (250) @(posedge clk);
    $display("run covered %0d items over %0d register settings", sent, Phases);
    $display("%0d result beats compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
